### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the gradient grid peak selector.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ggps_pkg.sv
// Package of the gradient grid peak selector: constants, register indexes,
// controller state type and the controller/datapath command and status structs.
// No dependencies.
package ggps_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_CELLS  = 32;

    localparam int PIX_W       = 8;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int DIM_CFG_W   = 11;
    localparam int CELL_CFG_W  = 6;
    localparam int BYTE_CFG_W  = 8;
    localparam int CELL_OUT_W  = 5;
    localparam int COORD_OUT_W = 10;
    localparam int MIN_DIM     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_DOWN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRAD_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_MARGIN  = 3'd5;

    localparam logic [DIM_CFG_W-1:0]  RST_IMAGE_WIDTH  = 11'd752;
    localparam logic [DIM_CFG_W-1:0]  RST_IMAGE_HEIGHT = 11'd480;
    localparam logic [CELL_CFG_W-1:0] RST_CELLS_ACROSS = 6'd25;
    localparam logic [CELL_CFG_W-1:0] RST_CELLS_DOWN   = 6'd15;

    typedef enum logic [2:0] {
        S_INIT,
        S_GEO,
        S_IDLE,
        S_LOAD,
        S_VIS_A,
        S_VIS_B,
        S_FLUSH_RD,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic geo_start;
        logic accept;
        logic load;
        logic flush_mode;
        logic visit_a;
        logic visit_b;
        logic flush_clear;
        logic flush_inc;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic geo_done;
        logic out_blocked;
        logic frame_last;
        logic flush_last;
    } dp_status_t;

    typedef struct packed {
        logic [CELL_OUT_W-1:0]  cell_col;
        logic [CELL_OUT_W-1:0]  cell_row;
        logic [COORD_OUT_W-1:0] peak_x;
        logic [COORD_OUT_W-1:0] peak_y;
        logic [PIX_W-1:0]       peak_value;
        logic                   selected;
    } result_t;

endpackage

### rtl/ggps_if.sv
// Stream interfaces of the gradient grid peak selector: pixel input and peak output.
// Depends on ggps_pkg.
interface ggps_pix_if import ggps_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             keep;

    modport source (output valid, output pixel, output keep, input ready);
    modport sink   (input valid, input pixel, input keep, output ready);
endinterface

interface ggps_peak_if import ggps_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CELL_OUT_W-1:0]  cell_col;
    logic [CELL_OUT_W-1:0]  cell_row;
    logic [COORD_OUT_W-1:0] peak_x;
    logic [COORD_OUT_W-1:0] peak_y;
    logic [PIX_W-1:0]       peak_value;
    logic                   selected;
    logic                   last;

    modport source (output valid, output cell_col, output cell_row, output peak_x,
                    output peak_y, output peak_value, output selected, output last,
                    input ready);
    modport sink   (input valid, input cell_col, input cell_row, input peak_x,
                    input peak_y, input peak_value, input selected, input last,
                    output ready);
endinterface

### rtl/ggps_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ggps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ggps_div.sv
// Restoring divider, one quotient bit per cycle; used for the grid cell size.
// No dependencies.
module ggps_div #(
    parameter int NW = 11,
    parameter int DW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [NW-1:0] quotient,
    output logic          done
);

    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] rem_reg;
    logic [NW-1:0] q_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {rem_reg, q_reg[NW-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(NW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            q_reg   <= {q_reg[NW-2:0], ge};
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

### rtl/ggps_ctrl.sv
// Controller of the gradient grid peak selector: sequences geometry setup,
// per-pixel window load and visits, end-of-frame row flush and result closing.
// Depends on ggps_pkg.
module ggps_ctrl import ggps_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        flush_reg, flush_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        flush_next     = flush_reg;
        cmd            = '0;
        cmd.flush_mode = flush_reg;
        in_ready       = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.geo_start = 1'b1;
                state_next    = S_GEO;
            end
            S_GEO:
            begin
                if (sts.geo_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = !cfg_write;
                if (in_valid && !cfg_write)
                begin
                    cmd.accept = 1'b1;
                    flush_next = 1'b0;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_VIS_A;
            end
            S_VIS_A:
            begin
                if (!sts.out_blocked)
                begin
                    cmd.visit_a = 1'b1;
                    state_next  = S_VIS_B;
                end
            end
            S_VIS_B:
            begin
                if (!sts.out_blocked)
                begin
                    cmd.visit_b = 1'b1;
                    if (flush_reg)
                    begin
                        if (sts.flush_last)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.flush_inc = 1'b1;
                            state_next    = S_FLUSH_RD;
                        end
                    end
                    else if (sts.frame_last)
                    begin
                        // bottom row is formed from the two stored rows
                        cmd.flush_clear = 1'b1;
                        flush_next      = 1'b1;
                        state_next      = S_FLUSH_RD;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FLUSH_RD:
            begin
                state_next = S_LOAD;
            end
            S_FINISH:
            begin
                if (!sts.out_blocked)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
        if (cfg_write)
        begin
            state_next = S_INIT;
            flush_next = 1'b0;
        end
    end

endmodule

### rtl/ggps_dp.sv
// Datapath of the gradient grid peak selector: config registers, geometry dividers,
// line buffer, 3x3 window, Sobel magnitude, per-cell peak tracking and result staging.
// Depends on ggps_pkg, ggps_ram, ggps_div.
module ggps_dp import ggps_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_CELLS  = DEF_MAX_CELLS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             sts,
    input  logic [PIX_W-1:0]       pixel,
    input  logic                   keep,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CELL_OUT_W-1:0]  cell_col,
    output logic [CELL_OUT_W-1:0]  cell_row,
    output logic [COORD_OUT_W-1:0] peak_x,
    output logic [COORD_OUT_W-1:0] peak_y,
    output logic [PIX_W-1:0]       peak_value,
    output logic                   selected,
    output logic                   last
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int GW_W  = $clog2(MAX_WIDTH + 1);
    localparam int GH_W  = $clog2(MAX_HEIGHT + 1);
    localparam int NC_W  = $clog2(MAX_CELLS + 1);
    localparam int CI_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int ENT_W = 2 * PIX_W + 1;

    function automatic int clamp_i(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [PIX_W-1:0] sobel_mag(
        input logic [PIX_W-1:0] l0, input logic [PIX_W-1:0] l1, input logic [PIX_W-1:0] l2,
        input logic [PIX_W-1:0] c0, input logic [PIX_W-1:0] c2,
        input logic [PIX_W-1:0] r0, input logic [PIX_W-1:0] r1, input logic [PIX_W-1:0] r2);
        logic [PIX_W+1:0]        rs, ls, ts, bs;
        logic signed [PIX_W+2:0] gx, gy;
        logic [PIX_W-1:0]        cx, cy;
        logic [PIX_W:0]          s;
        logic [PIX_W-1:0]        q;
        rs = {2'b00, r0} + {1'b0, r1, 1'b0} + {2'b00, r2};
        ls = {2'b00, l0} + {1'b0, l1, 1'b0} + {2'b00, l2};
        bs = {2'b00, l2} + {1'b0, c2, 1'b0} + {2'b00, r2};
        ts = {2'b00, l0} + {1'b0, c0, 1'b0} + {2'b00, r0};
        gx = $signed({1'b0, rs}) - $signed({1'b0, ls});
        gy = $signed({1'b0, bs}) - $signed({1'b0, ts});
        cx = gx[PIX_W+2] ? '0 : ((gx > 11'sd255) ? 8'd255 : gx[PIX_W-1:0]);
        cy = gy[PIX_W+2] ? '0 : ((gy > 11'sd255) ? 8'd255 : gy[PIX_W-1:0]);
        s  = {1'b0, cx} + {1'b0, cy};
        q  = s[PIX_W:1];
        // round half to even
        if (s[0] && q[0])
        begin
            q = q + 1'b1;
        end
        return q;
    endfunction

    // configuration
    logic [DIM_CFG_W-1:0]  width_reg, height_reg;
    logic [CELL_CFG_W-1:0] across_reg, down_reg;
    logic [BYTE_CFG_W-1:0] thr_reg, margin_reg;
    logic                  cfg_hit;

    always_comb
    begin
        case (cfg_index)
            REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_CELLS_ACROSS, REG_CELLS_DOWN,
            REG_GRAD_THRESHOLD, REG_BORDER_MARGIN: cfg_hit = cfg_write;
            default:                               cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            across_reg <= RST_CELLS_ACROSS;
            down_reg   <= RST_CELLS_DOWN;
            thr_reg    <= '0;
            margin_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:    width_reg  <= cfg_data[DIM_CFG_W-1:0];
                REG_IMAGE_HEIGHT:   height_reg <= cfg_data[DIM_CFG_W-1:0];
                REG_CELLS_ACROSS:   across_reg <= cfg_data[CELL_CFG_W-1:0];
                REG_CELLS_DOWN:     down_reg   <= cfg_data[CELL_CFG_W-1:0];
                REG_GRAD_THRESHOLD: thr_reg    <= cfg_data[BYTE_CFG_W-1:0];
                REG_BORDER_MARGIN:  margin_reg <= cfg_data[BYTE_CFG_W-1:0];
                default:            ;
            endcase
        end
    end

    // effective geometry
    logic [GW_W-1:0] gw, gcw;
    logic [GH_W-1:0] gh, gch;
    logic [NC_W-1:0] gnx, gny;
    logic            div_x_done, div_y_done;
    logic [XW-1:0]   gw_m1;
    logic [YW-1:0]   gh_m1;

    assign gw    = GW_W'(clamp_i(int'(width_reg), MIN_DIM, MAX_WIDTH));
    assign gh    = GH_W'(clamp_i(int'(height_reg), MIN_DIM, MAX_HEIGHT));
    assign gnx   = NC_W'(clamp_i(int'(across_reg), 1,
                                 (MAX_CELLS < int'(gw)) ? MAX_CELLS : int'(gw)));
    assign gny   = NC_W'(clamp_i(int'(down_reg), 1,
                                 (MAX_CELLS < int'(gh)) ? MAX_CELLS : int'(gh)));
    assign gw_m1 = XW'(gw - 1'b1);
    assign gh_m1 = YW'(gh - 1'b1);

    ggps_div #(.NW(GW_W), .DW(NC_W)) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.geo_start),
        .dividend (gw),
        .divisor  (gnx),
        .quotient (gcw),
        .done     (div_x_done)
    );

    ggps_div #(.NW(GH_W), .DW(NC_W)) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.geo_start),
        .dividend (gh),
        .divisor  (gny),
        .quotient (gch),
        .done     (div_y_done)
    );

    // stream position and captured input
    logic [XW-1:0]    px_col_reg, fcol_reg, fx_reg;
    logic [YW-1:0]    px_row_reg;
    logic [PIX_W-1:0] pix_reg;
    logic             keep_reg;
    logic             frame_last;

    assign frame_last = (px_col_reg == gw_m1) && (px_row_reg == gh_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_col_reg <= '0;
            px_row_reg <= '0;
            fcol_reg   <= '0;
        end
        else
        begin
            if (cfg_hit || (cmd.finish && frame_last))
            begin
                px_col_reg <= '0;
                px_row_reg <= '0;
            end
            else if (cmd.finish)
            begin
                if (px_col_reg == gw_m1)
                begin
                    px_col_reg <= '0;
                    px_row_reg <= px_row_reg + 1'b1;
                end
                else
                begin
                    px_col_reg <= px_col_reg + 1'b1;
                end
            end
            if (cmd.flush_clear)
            begin
                fcol_reg <= '0;
            end
            else if (cmd.flush_inc)
            begin
                fcol_reg <= fcol_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg  <= pixel;
            keep_reg <= keep;
        end
    end

    // line buffer: each column holds the two previous rows and the newer row's keep
    logic [ENT_W-1:0] ent;
    logic [PIX_W-1:0] ent_old, ent_new;
    logic             ent_keep;

    assign ent_old  = ent[ENT_W-1 -: PIX_W];
    assign ent_new  = ent[PIX_W:1];
    assign ent_keep = ent[0];

    ggps_ram #(.WIDTH(ENT_W), .DEPTH(MAX_WIDTH)) u_line (
        .clk   (clk),
        .we    (cmd.load && !cmd.flush_mode),
        .waddr (px_col_reg),
        .wdata ({ent_new, pix_reg, keep_reg}),
        .raddr (cmd.flush_mode ? fcol_reg : px_col_reg),
        .rdata (ent)
    );

    // 3x3 window, column 2 newest
    logic [PIX_W-1:0] t_reg [3];
    logic [PIX_W-1:0] m_reg [3];
    logic [PIX_W-1:0] b_reg [3];
    logic             k1_reg, k2_reg;
    logic [PIX_W-1:0] nt, nb;

    // during the flush the missing bottom row mirrors the top
    assign nt = (cmd.flush_mode || (px_row_reg != YW'(1))) ? ent_old : pix_reg;
    assign nb = cmd.flush_mode ? ent_old : pix_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            t_reg[0] <= t_reg[1];
            t_reg[1] <= t_reg[2];
            t_reg[2] <= nt;
            m_reg[0] <= m_reg[1];
            m_reg[1] <= m_reg[2];
            m_reg[2] <= ent_new;
            b_reg[0] <= b_reg[1];
            b_reg[1] <= b_reg[2];
            b_reg[2] <= nb;
            k1_reg   <= k2_reg;
            k2_reg   <= ent_keep;
            fx_reg   <= cmd.flush_mode ? fcol_reg : px_col_reg;
        end
    end

    // visit of one magnitude
    logic                row_ok, vis_en, left_edge;
    logic [XW-1:0]       vcol;
    logic [YW-1:0]       vrow;
    logic [PIX_W-1:0]    sl_t, sl_m, sl_b, sc_t, sc_b, sr_t, sr_m, sr_b;
    logic [PIX_W-1:0]    vmag;
    logic                vkeep;

    assign row_ok    = cmd.flush_mode || (px_row_reg != '0);
    assign vis_en    = row_ok && ((cmd.visit_a && (fx_reg != '0))
                                  || (cmd.visit_b && (fx_reg == gw_m1)));
    assign left_edge = (fx_reg == XW'(1));
    assign vcol      = cmd.visit_b ? fx_reg : XW'(fx_reg - 1'b1);
    assign vrow      = cmd.flush_mode ? px_row_reg : YW'(px_row_reg - 1'b1);
    assign vkeep     = cmd.visit_b ? k2_reg : k1_reg;

    always_comb
    begin
        if (cmd.visit_b)
        begin
            // right edge mirrors the left neighbor
            sl_t = t_reg[1]; sl_m = m_reg[1]; sl_b = b_reg[1];
            sc_t = t_reg[2]; sc_b = b_reg[2];
            sr_t = t_reg[1]; sr_m = m_reg[1]; sr_b = b_reg[1];
        end
        else
        begin
            sl_t = left_edge ? t_reg[2] : t_reg[0];
            sl_m = left_edge ? m_reg[2] : m_reg[0];
            sl_b = left_edge ? b_reg[2] : b_reg[0];
            sc_t = t_reg[1]; sc_b = b_reg[1];
            sr_t = t_reg[2]; sr_m = m_reg[2]; sr_b = b_reg[2];
        end
    end

    assign vmag = sobel_mag(sl_t, sl_m, sl_b, sc_t, sc_b, sr_t, sr_m, sr_b);

    // cell tracking
    logic [XW-1:0]    ccnt_reg, cc;
    logic [YW-1:0]    rcnt_reg, rc;
    logic [NC_W-1:0]  ci_reg, cj_reg, ci, cj;
    logic [NC_W-1:0]  rescnt_reg;
    logic [CI_W-1:0]  cidx;
    logic             in_grid, cell_start, end_x, end_y, emit, in_margin;
    logic [PIX_W-1:0] bv_reg [MAX_CELLS];
    logic [XW-1:0]    bx_reg [MAX_CELLS];
    logic [YW-1:0]    by_reg [MAX_CELLS];
    logic             bk_reg [MAX_CELLS];
    logic [PIX_W-1:0] cur_v, new_v;
    logic [XW-1:0]    new_x;
    logic [YW-1:0]    new_y;
    logic             new_k, take;
    result_t          res;

    assign cc         = (vcol == '0) ? '0 : ccnt_reg;
    assign ci         = (vcol == '0) ? '0 : ci_reg;
    assign rc         = (vrow == '0) ? '0 : rcnt_reg;
    assign cj         = (vrow == '0) ? '0 : cj_reg;
    assign in_grid    = (ci < gnx) && (cj < gny);
    assign cidx       = ci[CI_W-1:0];
    assign cell_start = (cc == '0) && (rc == '0);
    assign end_x      = (cc == XW'(gcw - 1'b1));
    assign end_y      = (rc == YW'(gch - 1'b1));
    assign cur_v      = bv_reg[cidx];
    assign take       = cell_start || (vmag > cur_v);
    assign new_v      = take ? vmag : cur_v;
    assign new_x      = take ? vcol : bx_reg[cidx];
    assign new_y      = take ? vrow : by_reg[cidx];
    assign new_k      = take ? vkeep : bk_reg[cidx];
    assign emit       = vis_en && in_grid && end_x && end_y
                        && (rescnt_reg < NC_W'(MAX_CELLS));
    assign in_margin  = (int'(new_x) >= int'(margin_reg))
                        && (int'(new_y) >= int'(margin_reg))
                        && (int'(new_x) + int'(margin_reg) < int'(gw))
                        && (int'(new_y) + int'(margin_reg) < int'(gh));

    assign res.cell_col   = CELL_OUT_W'(ci);
    assign res.cell_row   = CELL_OUT_W'(cj);
    assign res.peak_x     = COORD_OUT_W'(new_x);
    assign res.peak_y     = COORD_OUT_W'(new_y);
    assign res.peak_value = new_v;
    assign res.selected   = (new_v > thr_reg) && in_margin && new_k;

    always_ff @(posedge clk)
    begin
        if (vis_en && in_grid)
        begin
            bv_reg[cidx] <= new_v;
            bx_reg[cidx] <= new_x;
            by_reg[cidx] <= new_y;
            bk_reg[cidx] <= new_k;
        end
        if (vis_en)
        begin
            if (end_x)
            begin
                ccnt_reg <= '0;
                ci_reg   <= (ci < gnx) ? ci + 1'b1 : ci;
            end
            else
            begin
                ccnt_reg <= cc + 1'b1;
                ci_reg   <= ci;
            end
            if (cmd.visit_b)
            begin
                if (end_y)
                begin
                    rcnt_reg <= '0;
                    cj_reg   <= (cj < gny) ? cj + 1'b1 : cj;
                end
                else
                begin
                    rcnt_reg <= rc + 1'b1;
                    cj_reg   <= cj;
                end
            end
        end
    end

    // result staging: the newest result waits in pend until the next one or the
    // end of the step tells whether it is the last
    result_t pend_reg, out_reg;
    logic    pend_valid_reg, out_valid_reg, out_last_reg, out_free, load_out;

    assign out_free = !out_valid_reg || out_ready;
    assign load_out = pend_valid_reg && (emit || cmd.finish);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            rescnt_reg     <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.accept)
            begin
                rescnt_reg <= '0;
            end
            else if (emit)
            begin
                rescnt_reg <= rescnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pend_reg <= res;
        end
        if (load_out)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= cmd.finish;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_col   = out_reg.cell_col;
    assign cell_row   = out_reg.cell_row;
    assign peak_x     = out_reg.peak_x;
    assign peak_y     = out_reg.peak_y;
    assign peak_value = out_reg.peak_value;
    assign selected   = out_reg.selected;
    assign last       = out_last_reg;

    assign sts.geo_done    = div_x_done && div_y_done;
    assign sts.out_blocked = pend_valid_reg && !out_free;
    assign sts.frame_last  = frame_last;
    assign sts.flush_last  = (fcol_reg == gw_m1);

endmodule

### rtl/gradient_grid_peak_select.sv
// A pixel passes through accept, line buffer load, two visit slots and close; the visits
// and close wait while the peak output is blocked. For the final pixel of a frame the
// bottom row is flushed column by column (flush read, load, two visit slots) through
// the line buffer's single read port. A new pixel is taken only once the previous one
// is closed. Reset, and any register write, runs the geometry dividers before the
// first pixel is taken; reset or a known register's write restarts the frame at pixel 0.
module gradient_grid_peak_select import ggps_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_CELLS  = DEF_MAX_CELLS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ggps_pix_if.sink              pixels,
    ggps_peak_if.source           peaks,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    ggps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .in_valid  (pixels.valid),
        .in_ready  (pixels.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ggps_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_CELLS  (MAX_CELLS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .sts        (sts),
        .pixel      (pixels.pixel),
        .keep       (pixels.keep),
        .out_valid  (peaks.valid),
        .out_ready  (peaks.ready),
        .cell_col   (peaks.cell_col),
        .cell_row   (peaks.cell_row),
        .peak_x     (peaks.peak_x),
        .peak_y     (peaks.peak_y),
        .peak_value (peaks.peak_value),
        .selected   (peaks.selected),
        .last       (peaks.last)
    );

`include "assert_macros.svh"

    // an accepted pixel goes straight to the line buffer load
    `ASSERT_NEXT(a_accept_load, clk, rst_n, pixels.valid && pixels.ready, cmd.load, "accepted pixel not loaded")
    // no visit or close while a pending result cannot move out
    `ASSERT_IMPLY(a_no_overrun, clk, rst_n, cmd.visit_a || cmd.visit_b || cmd.finish, !sts.out_blocked, "result staging overrun")
    // a register write recomputes geometry before the next pixel
    `ASSERT_NEXT(a_cfg_restart, clk, rst_n, cfg_write, !pixels.ready, "pixel taken during geometry setup")

endmodule

### tb/tb.sv
// Testbench of the gradient grid peak selector: drives pixel frames under several
// grid settings and checks every peak result against a built-in predictor.
// Depends on ggps_pkg, ggps_if and the gradient_grid_peak_select RTL.
`timescale 1ns / 100ps

module tb;
    import ggps_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int LINE_DEPTH   = 1024;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct {
        result_t    res;
        logic       last;
    } peak_rec_t;

    class peak_board;
        logic [7:0]  lines[2*LINE_DEPTH];
        bit          keeps[2*LINE_DEPTH];
        int unsigned best_val[32], best_x[32], best_y[32];
        bit          best_keep[32];
        int unsigned col, row;
        int unsigned win_t[3], win_m[3], win_b[3];
        int unsigned img_w, img_h, cells_x, cells_y, thresh, margin;
        int unsigned gw, gh, gnx, gny, gcw, gch;
        peak_rec_t   pending_peaks[$];
        int          errors, matched, pixels_seen;

        function new();
            foreach (lines[i])
            begin
                lines[i] = 0;
                keeps[i] = 0;
            end
            foreach (best_val[i])
            begin
                best_val[i] = 0;
                best_x[i] = 0;
                best_y[i] = 0;
                best_keep[i] = 0;
            end
            for (int i = 0; i < 3; i++)
            begin
                win_t[i] = 0;
                win_m[i] = 0;
                win_b[i] = 0;
            end
            col = 0;
            row = 0;
            img_w = RST_IMAGE_WIDTH;
            img_h = RST_IMAGE_HEIGHT;
            cells_x = RST_CELLS_ACROSS;
            cells_y = RST_CELLS_DOWN;
            thresh = 0;
            margin = 0;
            errors = 0;
            matched = 0;
            pixels_seen = 0;
        endfunction

        function int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void geometry();
            gw = clampu(img_w, 3, DEF_MAX_WIDTH);
            gh = clampu(img_h, 3, DEF_MAX_HEIGHT);
            gnx = clampu(cells_x, 1, gw < DEF_MAX_CELLS ? gw : DEF_MAX_CELLS);
            gny = clampu(cells_y, 1, gh < DEF_MAX_CELLS ? gh : DEF_MAX_CELLS);
            gcw = gw / gnx;
            gch = gh / gny;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
            case (idx)
                REG_IMAGE_WIDTH:    img_w = val & 11'h7FF;
                REG_IMAGE_HEIGHT:   img_h = val & 11'h7FF;
                REG_CELLS_ACROSS:   cells_x = val & 6'h3F;
                REG_CELLS_DOWN:     cells_y = val & 6'h3F;
                REG_GRAD_THRESHOLD: thresh = val & 8'hFF;
                REG_BORDER_MARGIN:  margin = val & 8'hFF;
                default: return;
            endcase
            col = 0;
            row = 0;
            geometry();
        endfunction

        function int unsigned clip8(int v);
            return v < 0 ? 0 : (v > 255 ? 255 : v);
        endfunction

        // l, c, r are columns given top, middle, bottom
        function int unsigned sobel_mag(int unsigned l[3], int unsigned c[3],
                                        int unsigned r[3]);
            int gx, gy;
            int unsigned s, q;
            gx = (int'(r[0]) + 2*int'(r[1]) + int'(r[2]))
               - (int'(l[0]) + 2*int'(l[1]) + int'(l[2]));
            gy = (int'(l[2]) + 2*int'(c[2]) + int'(r[2]))
               - (int'(l[0]) + 2*int'(c[0]) + int'(r[0]));
            s = clip8(gx) + clip8(gy);
            q = s >> 1;
            if (s[0] && q[0])
                q++;
            return q;
        endfunction

        function void track_cell(int unsigned x, int unsigned y, int unsigned v,
                                 bit k, ref int n);
            int unsigned i, j, x0, y0, px, py;
            bit in_margin;
            peak_rec_t rec;
            if (x >= gcw * gnx || y >= gch * gny)
                return;
            i = x / gcw;
            j = y / gch;
            x0 = i * gcw;
            y0 = j * gch;
            if ((x == x0 && y == y0) || v > best_val[i])
            begin
                best_val[i] = v;
                best_x[i] = x;
                best_y[i] = y;
                best_keep[i] = k;
            end
            if (x == x0 + gcw - 1 && y == y0 + gch - 1 && n < 32)
            begin
                px = best_x[i];
                py = best_y[i];
                in_margin = px >= margin && py >= margin && px + margin < gw
                            && py + margin < gh;
                rec.res.cell_col = CELL_OUT_W'(i);
                rec.res.cell_row = CELL_OUT_W'(j);
                rec.res.peak_x = COORD_OUT_W'(px);
                rec.res.peak_y = COORD_OUT_W'(py);
                rec.res.peak_value = PIX_W'(best_val[i]);
                rec.res.selected = best_val[i] > thresh && in_margin && best_keep[i];
                rec.last = 1'b0;
                pending_peaks = {pending_peaks, rec};
                n++;
            end
        endfunction

        function void note_pixel(logic [7:0] p, bit k);
            int unsigned x, y, cur, prv, ks, mrow, orow, lc, rc;
            int unsigned lft[3], ctr[3], rgt[3];
            int n;
            n = 0;
            pixels_seen++;
            geometry();
            if (col >= gw || row >= gh)
            begin
                col = 0;
                row = 0;
            end
            x = col;
            y = row;
            cur = (y & 1) * LINE_DEPTH + x;
            prv = ((y + 1) & 1) * LINE_DEPTH + x;
            for (int i = 0; i < 2; i++)
            begin
                win_t[i] = win_t[i+1];
                win_m[i] = win_m[i+1];
                win_b[i] = win_b[i+1];
            end
            win_t[2] = (y == 1) ? p : lines[cur];
            win_m[2] = lines[prv];
            win_b[2] = p;
            lines[cur] = p;
            keeps[cur] = k;

            if (y >= 1 && x >= 1)
            begin
                ks = ((y - 1) & 1) * LINE_DEPTH;
                ctr = '{win_t[1], win_m[1], win_b[1]};
                rgt = '{win_t[2], win_m[2], win_b[2]};
                if (x == 1)
                    lft = rgt;
                else
                    lft = '{win_t[0], win_m[0], win_b[0]};
                track_cell(x - 1, y - 1, sobel_mag(lft, ctr, rgt), keeps[ks + x - 1], n);
                if (x == gw - 1)
                    track_cell(x, y - 1, sobel_mag(ctr, rgt, ctr), keeps[ks + x], n);
            end

            if (x == gw - 1 && y == gh - 1)
            begin
                // bottom row: reflect-101 mirrors the row above into the one below
                mrow = (y & 1) * LINE_DEPTH;
                orow = ((y + 1) & 1) * LINE_DEPTH;
                for (int unsigned c = 0; c < gw; c++)
                begin
                    lc = (c == 0) ? 1 : c - 1;
                    rc = (c + 1 >= gw) ? gw - 2 : c + 1;
                    lft = '{lines[orow+lc], lines[mrow+lc], lines[orow+lc]};
                    ctr = '{lines[orow+c], lines[mrow+c], lines[orow+c]};
                    rgt = '{lines[orow+rc], lines[mrow+rc], lines[orow+rc]};
                    track_cell(c, y, sobel_mag(lft, ctr, rgt), keeps[mrow + c], n);
                end
                col = 0;
                row = 0;
            end
            else if (x == gw - 1)
            begin
                col = 0;
                row = y + 1;
            end
            else
            begin
                col = x + 1;
            end
            if (n > 0)
                pending_peaks[pending_peaks.size()-1].last = 1'b1;
        endfunction

        function void check_peak(result_t got, logic got_last);
            peak_rec_t exp;
            if (pending_peaks.size() == 0)
            begin
                $display("%0t: unexpected peak transfer %p last=%0b", $time, got, got_last);
                errors++;
                return;
            end
            exp = pending_peaks.pop_front();
            if (got.cell_col !== exp.res.cell_col || got.cell_row !== exp.res.cell_row
                || got.peak_x !== exp.res.peak_x || got.peak_y !== exp.res.peak_y
                || got.peak_value !== exp.res.peak_value
                || got.selected !== exp.res.selected || got_last !== exp.last)
            begin
                $display("%0t: peak mismatch expected %p last=%0b actual %p last=%0b",
                         $time, exp.res, exp.last, got, got_last);
                errors++;
            end
            else
            begin
                matched++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ggps_pix_if  pix ();
    ggps_peak_if pk ();

    gradient_grid_peak_select u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix),
        .peaks     (pk),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    peak_board board = new();
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_cycles = 0;
    int hold_off_req = 0;
    int hold_off_seen = 0;
    int cycle_count = 0;
    int frames_run;
    int configs_run;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stalls plus a long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && pk.valid && pk.ready)
            board.check_peak('{pk.cell_col, pk.cell_row, pk.peak_x, pk.peak_y,
                               pk.peak_value, pk.selected}, pk.last);
        if (!rst_n)
        begin
            pk.ready <= 1'b0;
        end
        else if (hold_off_req != hold_off_seen)
        begin
            hold_off_seen <= hold_off_req;
            hold_off_cycles <= HOLD_CYCLES;
            pk.ready <= 1'b0;
        end
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            pk.ready <= 1'b0;
        end
        else
        begin
            pk.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(posedge clk);
        board.write_reg(idx, val);
        cfg_write <= 1'b0;
    endtask

    task automatic send_pixel(logic [7:0] p, bit k);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.pixel <= p;
        pix.keep <= k;
        do
            @(posedge clk);
        while (!pix.ready);
        board.note_pixel(p, k);
    endtask

    // waits out all expected peaks, then the bottom-row flush of a frame end
    task automatic drain();
        pix.valid <= 1'b0;
        while (board.pending_peaks.size() > 0)
            @(posedge clk);
        repeat (4 * board.gw + 60) @(posedge clk);
    endtask

    task automatic setup_grid(int unsigned w, int unsigned h, int unsigned cx,
                              int unsigned cy, int unsigned thr, int unsigned mar);
        drain();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_CELLS_ACROSS, cx);
        write_reg(REG_CELLS_DOWN, cy);
        write_reg(REG_GRAD_THRESHOLD, thr);
        write_reg(REG_BORDER_MARGIN, mar);
        configs_run++;
    endtask

    function automatic logic [7:0] pick_pixel();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 8'd0;
        if (r == 1)
            return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    task automatic random_frame();
        int unsigned npix;
        npix = board.gw * board.gh;
        for (int unsigned i = 0; i < npix; i++)
            send_pixel(pick_pixel(), $urandom_range(3) != 0);
        frames_run++;
    endtask

    initial
    begin
        int random_items;
        int unsigned w, h;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pix.valid = 1'b0;
        pix.pixel = '0;
        pix.keep = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 48;
        frames_run = 0;
        configs_run = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero in the size and cell registers clamps to the smallest 3x3 image with one cell
        setup_grid(0, 0, 0, 0, 255, 255);
        write_reg(REG_UNUSED_LO, 11'h7FF);
        write_reg(REG_UNUSED_HI, 11'h7FF);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? 8'd255 : 8'd0, i[0]);
        setup_grid(3, 3, 1, 1, 0, 0);
        for (int i = 0; i < 9; i++)
            send_pixel((i < 3) ? 8'd255 : 8'd0, 1'b1);
        // margin at least half the size: nothing may be selected
        setup_grid(4, 4, 2, 2, 0, 2);
        for (int i = 0; i < 16; i++)
            send_pixel(8'(i * 17), 1'b1);

        // widest image, cell registers above their limit; the next write restarts it
        setup_grid(11'h7FF, 3, 6'h3F, 6'h3F, 10, 1);
        for (int i = 0; i < 16; i++)
            send_pixel(pick_pixel(), 1'b1);

        // one-pixel cells under a long receiver hold-off fill the staging and stall input
        setup_grid(6, 4, 6, 4, 0, 0);
        hold_off_req = hold_off_req + 1;
        random_frame();

        random_items = 0;
        while (random_items < 176)
        begin
            if (random_items < 59)
            begin
                send_idle_pct = 28;
                recv_idle_pct = 48;
            end
            else if (random_items < 118)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 28;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            w = $urandom_range(12, 3);
            h = $urandom_range(8, 3);
            setup_grid(w, h, ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(w, 1),
                       ($urandom_range(4) == 0) ? $urandom_range(63) : $urandom_range(h, 1),
                       ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(40),
                       ($urandom_range(5) == 0) ? $urandom_range(255) : $urandom_range(2));
            random_frame();
            random_items += w * h;
            if ($urandom_range(1))
            begin
                random_frame();
                random_items += w * h;
            end
        end

        drain();
        $display("covered %0d pixels in %0d frames over %0d grid settings",
                 board.pixels_seen, frames_run, configs_run);
        $display("%0d peak results matched, %0d errors", board.matched, board.errors);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

### gradient_grid_peak_select.f
+incdir+rtl
rtl/ggps_pkg.sv
rtl/ggps_if.sv
rtl/ggps_ram.sv
rtl/ggps_div.sv
rtl/ggps_ctrl.sv
rtl/ggps_dp.sv
rtl/gradient_grid_peak_select.sv
tb/tb.sv
